[src/geq_pkg.sv]
// Shared types and constants of the ten-band biquad equalizer.
// No dependencies; used by geq_front, geq_back, the top level and the testbench.
package geq_pkg;

  localparam int NUM_SLOTS = 5;
  localparam int SAMPLE_MAX_BITS = 32;

  localparam logic [1:0] CMD_FILTER = 2'd0;
  localparam logic [1:0] CMD_COEF   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Coefficient slots
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  // Band sequencer phases
  localparam logic [3:0] PH_HIST  = 4'd0;
  localparam logic [3:0] PH_ACC0  = 4'd2;
  localparam logic [3:0] PH_NEG0  = 4'd5;
  localparam logic [3:0] PH_ROUND = 4'd7;
  localparam logic [3:0] PH_WB    = 4'd8;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_PASS,
    OP_COEF,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    op_t                              op;
    logic                             channel;
    logic signed [SAMPLE_MAX_BITS-1:0] sample;
    logic [3:0]                       band;
    logic [2:0]                       slot;
    logic signed [31:0]               value;
  } item_t;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

endpackage

[src/geq_ifs.sv]
// Channel interfaces: sample/command items, result items, bypass writes.
// No dependencies.
interface geq_item_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic                          channel;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [3:0]                    band_index;
  logic [2:0]                    coef_select;
  logic signed [31:0]            coef_value;
  modport source (output valid, cmd, channel, in_sample, band_index, coef_select,
                  coef_value, input ready);
  modport sink (input valid, cmd, channel, in_sample, band_index, coef_select,
                coef_value, output ready);
endinterface

interface geq_res_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_channel;
  modport source (output valid, out_sample, out_channel, input ready);
  modport sink (input valid, out_sample, out_channel, output ready);
endinterface

interface geq_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[src/geq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module geq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/geq_front.sv]
// Front end: accepts items, holds the bypass register, classifies items
// and queues them (two entries) for the back end. Depends on geq_pkg, geq_ifs.
module geq_front
  import geq_pkg::*;
#(
  parameter int BANDS    = 10,
  parameter int CHANNELS = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  geq_item_if.sink   in_item,
  geq_cfg_if.sink    cfg_wr,
  output item_t      q_item,
  output logic       q_valid,
  input  logic       q_pop
);

  logic       bypass_r;
  item_t      fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       accept, keep, push;
  item_t      cls;

  assign cfg_wr.ready = 1'b1;
  assign in_item.ready = (cnt_r != 2'd2);
  assign accept = in_item.valid && in_item.ready;

  always_comb begin
    cls.channel = in_item.channel;
    cls.sample  = SAMPLE_MAX_BITS'(in_item.in_sample);
    cls.band    = in_item.band_index;
    cls.slot    = in_item.coef_select;
    cls.value   = in_item.coef_value;
    cls.op      = OP_CLEAR;
    keep        = 1'b0;
    unique case (in_item.cmd)
      CMD_FILTER: begin
        keep   = 1'b1;
        cls.op = (bypass_r || (32'(in_item.channel) >= CHANNELS)) ? OP_PASS : OP_SAMPLE;
      end
      CMD_COEF: begin
        cls.op = OP_COEF;
        keep   = (32'(in_item.band_index) < BANDS) &&
                 (32'(in_item.coef_select) < NUM_SLOTS);
      end
      CMD_CLEAR: begin
        cls.op = OP_CLEAR;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push    = accept && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
      wp_r     <= 1'b0;
      rp_r     <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        bypass_r <= cfg_wr.data;
      end
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cls;
    end
  end

endmodule

[src/geq_back.sv]
// Back end: executes queued items. Runs the biquad cascade one band at a time
// on a shared 32xN multiplier; coefficient and history RAMs; output register.
// Depends on geq_pkg, geq_ifs, geq_ram.
module geq_back
  import geq_pkg::*;
#(
  parameter int BANDS          = 10,
  parameter int CHANNELS       = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic      clk,
  input  logic      rst_n,
  input  item_t     q_item,
  input  logic      q_valid,
  output logic      q_pop,
  geq_res_if.source out_res
);

  localparam int SB  = SAMPLE_BITS;
  localparam int CD  = BANDS * NUM_SLOTS;
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int HD  = CHANNELS * BANDS;
  localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int BW  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int HW  = 4 * SB;
  localparam logic signed [31:0] COEF_ONE = 32'sd1 <<< COEF_FRAC_BITS;
  localparam logic signed [63:0] HALF     = 64'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [63:0] SMAX     = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN     = -(64'sd1 <<< (SB - 1));

  bk_state_t              state_r, state_nxt;
  logic [3:0]             phase_r, phase_nxt;
  logic [BW-1:0]          band_r, band_nxt;
  logic                   ch_r, ch_nxt;
  logic signed [SB-1:0]   x_r, x_nxt;
  logic signed [63:0]     acc_r, acc_nxt;
  logic signed [63:0]     prod_r;
  logic                   outv_r, outv_nxt;
  logic signed [SB-1:0]   res_r;
  logic                   och_r;
  logic [CD-1:0]          cvalid_r;
  logic [HD-1:0]          hvalid_r;
  logic                   cv_r, hv_r;

  logic                   coef_we, coef_re, hist_we, hist_re, out_free, hist_clr;
  logic [CAW-1:0]         coef_waddr, coef_raddr;
  logic [HAW-1:0]         hist_addr;
  logic [31:0]            coef_q;
  logic [HW-1:0]          hist_q, hist_wdata;
  logic signed [SB-1:0]   x1, x2, y1, y2, opnd, y;
  logic signed [31:0]     coef_eff;
  logic signed [32+SB-1:0] mul;
  logic signed [63:0]     shifted;
  logic [3:0]             dslot;

  geq_ram #(.WIDTH(32), .DEPTH(CD)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (q_item.value),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_q)
  );

  geq_ram #(.WIDTH(HW), .DEPTH(HD)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_addr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_addr),
    .rdata (hist_q)
  );

  assign out_free   = !outv_r || out_res.ready;
  assign coef_waddr = CAW'(32'(q_item.band) * NUM_SLOTS + 32'(q_item.slot));
  assign coef_raddr = CAW'(32'(band_r) * NUM_SLOTS + 32'(phase_r));
  assign coef_re    = (state_r == BK_RUN) && (32'(phase_r) < NUM_SLOTS);
  assign hist_re    = (state_r == BK_RUN) && (phase_r == PH_HIST);
  assign hist_addr  = HAW'(32'(ch_r) * BANDS + 32'(band_r));

  // never-written entries read as reset values
  assign x1 = hv_r ? hist_q[4*SB-1:3*SB] : '0;
  assign x2 = hv_r ? hist_q[3*SB-1:2*SB] : '0;
  assign y1 = hv_r ? hist_q[2*SB-1:SB]   : '0;
  assign y2 = hv_r ? hist_q[SB-1:0]      : '0;

  assign dslot    = phase_r - 4'd1;
  assign coef_eff = cv_r ? coef_q : ((dslot[2:0] == SLOT_B0) ? COEF_ONE : 32'sd0);

  always_comb begin
    case (dslot[2:0])
      SLOT_B1: opnd = x1;
      SLOT_B2: opnd = x2;
      SLOT_A1: opnd = y1;
      SLOT_A2: opnd = y2;
      default: opnd = x_r;
    endcase
  end

  assign mul     = coef_eff * opnd;
  assign shifted = acc_r >>> COEF_FRAC_BITS;

  always_comb begin
    if (shifted > SMAX) begin
      y = SMAX[SB-1:0];
    end else if (shifted < SMIN) begin
      y = SMIN[SB-1:0];
    end else begin
      y = shifted[SB-1:0];
    end
  end

  assign hist_wdata = {x_r, x1, y, y1};

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    band_nxt  = band_r;
    ch_nxt    = ch_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    outv_nxt  = outv_r && !out_res.ready;
    q_pop     = 1'b0;
    coef_we   = 1'b0;
    hist_we   = 1'b0;
    hist_clr  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          ch_nxt = q_item.channel;
          x_nxt  = q_item.sample[SB-1:0];
          unique case (q_item.op)
            OP_SAMPLE: begin
              state_nxt = BK_RUN;
              phase_nxt = PH_HIST;
              band_nxt  = '0;
            end
            OP_PASS:  state_nxt = BK_DONE;
            OP_COEF:  coef_we = 1'b1;
            OP_CLEAR: hist_clr = 1'b1;
            default:  state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_RUN: begin
        phase_nxt = phase_r + 4'd1;
        if (phase_r == PH_ACC0) begin
          acc_nxt = prod_r;
        end else if (phase_r > PH_ACC0 && phase_r < PH_NEG0) begin
          acc_nxt = sat_add(acc_r, prod_r);
        end else if (phase_r >= PH_NEG0 && phase_r < PH_ROUND) begin
          acc_nxt = sat_add(acc_r, -prod_r);
        end else if (phase_r == PH_ROUND) begin
          acc_nxt = sat_add(acc_r, HALF);
        end else if (phase_r == PH_WB) begin
          hist_we   = 1'b1;
          x_nxt     = y;
          phase_nxt = PH_HIST;
          if (32'(band_r) == BANDS - 1) begin
            state_nxt = BK_DONE;
          end else begin
            band_nxt = band_r + BW'(1);
          end
        end
      end
      BK_DONE: begin
        if (out_free) begin
          outv_nxt  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      phase_r  <= PH_HIST;
      band_r   <= '0;
      outv_r   <= 1'b0;
      cvalid_r <= '0;
      hvalid_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      band_r  <= band_nxt;
      outv_r  <= outv_nxt;
      if (coef_we) begin
        cvalid_r[coef_waddr] <= 1'b1;
      end
      if (hist_clr) begin
        hvalid_r <= '0;
      end else if (hist_we) begin
        hvalid_r[hist_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r  <= ch_nxt;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    if (coef_re) begin
      cv_r <= cvalid_r[coef_raddr];
    end
    if (hist_re) begin
      hv_r <= hvalid_r[hist_addr];
    end
    prod_r <= 64'(mul);
    if (state_r == BK_DONE && out_free) begin
      res_r <= x_r;
      och_r <= ch_r;
    end
  end

  assign out_res.valid       = outv_r;
  assign out_res.out_sample  = res_r;
  assign out_res.out_channel = och_r;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_IDLE) && q_valid)
    else $error("queue popped outside idle");
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    coef_we |-> !hist_we && !coef_re)
    else $error("coefficient write during band run");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN) |-> (phase_r <= PH_WB))
    else $error("band phase out of range");
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DONE) && out_free |=> outv_r && (state_r == BK_IDLE))
    else $error("result not loaded");
`endif

endmodule

[src/graphic_eq_biquad_cascade_core.sv]
// Channel     | dir | handshake          | payload
// in_item     | in  | valid/ready        | cmd, channel, in_sample, band_index,
//             |     |                    | coef_select, coef_value
// out_res     | out | valid/ready        | out_sample, out_channel
// cfg_wr      | in  | valid/ready        | data (bypass)
//
// A filtered sample runs one band at a time on the shared multiplier
// (5 coefficient reads, multiply-accumulate, round, write back) for each band.
// Coefficient and clear items execute on pop; bypassed items skip the cascade.
// A two-entry queue separates acceptance from execution; the output register
// holds a result while the next item is taken. Reset is synchronous, rst_n low;
// no clearing pass, valid bits give reset values of coefficients and histories.
// Depends on geq_pkg, geq_ifs, geq_front, geq_back.
module graphic_eq_biquad_cascade_core
  import geq_pkg::*;
#(
  parameter int BANDS          = 10,
  parameter int CHANNELS       = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic      clk,
  input  logic      rst_n,
  geq_item_if.sink  in_item,
  geq_res_if.source out_res,
  geq_cfg_if.sink   cfg_wr
);

  item_t q_item;
  logic  q_valid, q_pop;

  geq_front #(.BANDS(BANDS), .CHANNELS(CHANNELS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cfg_wr  (cfg_wr),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  geq_back #(
    .BANDS          (BANDS),
    .CHANNELS       (CHANNELS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

endmodule

[verif/graphic_eq_biquad_cascade_core_tb.sv]
// Testbench of the ten-band biquad equalizer: directed and random items, predicted
// band by band in Direct Form I and checked against every result item.
// Depends on geq_pkg, geq_ifs and graphic_eq_biquad_cascade_core.
module graphic_eq_biquad_cascade_core_tb;
  import geq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BANDS = 10;
  localparam int CHANNELS = 2;
  localparam int SBITS = 24;
  localparam int FRAC = 28;
  localparam int DRAIN_CYCLES = 9 * BANDS + 20;
  // command code with no meaning; the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic signed [SBITS-1:0] smp;
    logic                    ch;
  } eq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  geq_item_if #(.SAMPLE_BITS(SBITS)) item_ch ();
  geq_res_if #(.SAMPLE_BITS(SBITS)) res_ch ();
  geq_cfg_if cfg_ch ();

  graphic_eq_biquad_cascade_core #(
    .BANDS(BANDS), .CHANNELS(CHANNELS), .SAMPLE_BITS(SBITS), .COEF_FRAC_BITS(FRAC)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_item(item_ch.sink), .out_res(res_ch.source),
    .cfg_wr(cfg_ch.sink)
  );

  // predictor state
  logic signed [31:0] coef_tbl[BANDS][NUM_SLOTS];
  logic signed [SBITS-1:0] x1_hist[CHANNELS][BANDS], x2_hist[CHANNELS][BANDS];
  logic signed [SBITS-1:0] y1_hist[CHANNELS][BANDS], y2_hist[CHANNELS][BANDS];
  logic bypass_on;

  eq_result_t pending_samples[$];
  int errors = 0;
  bit idle_enable = 1'b1;

  task automatic report(input string what, input string got, input string want);
    errors++;
    $display("mismatch %s: got %s expected %s at %0t", what, got, want, $realtime);
  endtask

  function automatic void clear_hist();
    for (int c = 0; c < CHANNELS; c++)
      for (int b = 0; b < BANDS; b++) begin
        x1_hist[c][b] = '0; x2_hist[c][b] = '0; y1_hist[c][b] = '0; y2_hist[c][b] = '0;
      end
  endfunction

  function automatic logic signed [63:0] acc_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [SBITS-1:0] run_band(int b, int c, logic signed [SBITS-1:0] x);
    logic signed [63:0] acc, r;
    logic signed [SBITS-1:0] y;
    acc = 64'(coef_tbl[b][0]) * 64'(x);
    acc = acc_add(acc, 64'(coef_tbl[b][1]) * 64'(x1_hist[c][b]));
    acc = acc_add(acc, 64'(coef_tbl[b][2]) * 64'(x2_hist[c][b]));
    acc = acc_add(acc, -(64'(coef_tbl[b][3]) * 64'(y1_hist[c][b])));
    acc = acc_add(acc, -(64'(coef_tbl[b][4]) * 64'(y2_hist[c][b])));
    acc = acc_add(acc, 64'sd1 <<< (FRAC - 1));
    r = acc >>> FRAC;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    y = r[SBITS-1:0];
    x2_hist[c][b] = x1_hist[c][b]; x1_hist[c][b] = x;
    y2_hist[c][b] = y1_hist[c][b]; y1_hist[c][b] = y;
    return y;
  endfunction

  function automatic void predict_item(logic [1:0] cmd, logic ch, logic signed [SBITS-1:0] smp,
                                       logic [3:0] band, logic [2:0] slot, logic signed [31:0] val);
    eq_result_t r;
    if (cmd == CMD_FILTER) begin
      r.smp = smp;
      r.ch = ch;
      if (!bypass_on && ch < CHANNELS)
        for (int b = 0; b < BANDS; b++) r.smp = run_band(b, ch, r.smp);
      pending_samples.push_back(r);
    end else if (cmd == CMD_COEF) begin
      if (band < BANDS && slot < NUM_SLOTS) coef_tbl[band][slot] = val;
    end else if (cmd == CMD_CLEAR) begin
      clear_hist();
    end
  endfunction

  // valid stays high between items unless a gap is taken or the bench drains
  task automatic idle_gap();
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic send_item(logic [1:0] cmd, logic ch, logic signed [SBITS-1:0] smp,
                           logic [3:0] band, logic [2:0] slot, logic signed [31:0] val);
    idle_gap();
    item_ch.valid <= 1'b1;
    item_ch.cmd <= cmd; item_ch.channel <= ch; item_ch.in_sample <= smp;
    item_ch.band_index <= band; item_ch.coef_select <= slot; item_ch.coef_value <= val;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_item(cmd, ch, smp, band, slot, val);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_bypass(logic v);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    bypass_on = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(logic ch, logic signed [SBITS-1:0] s);
    send_item(CMD_FILTER, ch, s, 4'($urandom), 3'($urandom), $urandom);
  endtask

  task automatic send_coef(int band, logic [2:0] slot, logic signed [31:0] v);
    send_item(CMD_COEF, 1'($urandom), SBITS'($urandom), 4'(band), slot, v);
  endtask

  // moderate coefficients keep most outputs out of saturation
  function automatic logic signed [31:0] mild_coef(logic [2:0] slot);
    int span;
    span = (slot == SLOT_B0) ? (1 << 28) : (1 << 25);
    return $signed((slot == SLOT_B0 ? (1 << 28) : 0) + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic test_directed();
    send_sample(1'b0, 24'sh7FFFFF);
    send_sample(1'b1, -24'sh800000);
    send_sample(1'b0, '0);
    send_coef(0, SLOT_B0, 32'sh7FFFFFFF);
    send_coef(0, SLOT_B1, -32'sh80000000);
    send_coef(1, SLOT_A1, 32'sh7FFFFFFF);
    send_coef(2, SLOT_A2, -32'sh80000000);
    send_coef(9, SLOT_B2, 32'sh1000_0000);
    send_coef(10, SLOT_B0, 32'sh0);     // band out of range: ignored
    send_coef(15, SLOT_B0, 32'sh0);
    send_coef(3, 3'd5, 32'sh0);         // slot out of range: ignored
    send_coef(3, 3'd7, 32'sh0);
    send_sample(1'b0, 24'sh7FFFFF);
    send_sample(1'b0, -24'sh800000);
    send_sample(1'b1, 24'sh7FFFFF);
    send_item(CMD_CLEAR, 1'b0, '1, '1, '1, '1);
    send_item(CMD_UNUSED, 1'b1, '1, '1, '1, '1);
    send_sample(1'b0, 24'sh123456);
    write_bypass(1'b1);
    send_sample(1'b1, -24'sh800000);
    send_sample(1'b0, 24'sh7FFFFF);
    write_bypass(1'b0);
    send_sample(1'b1, 24'sh000001);
    send_item(CMD_CLEAR, 1'b0, '0, '0, '0, '0);
  endtask

  task automatic test_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_sample(1'($urandom), (pick < 10) ? SBITS'($urandom) :
                    SBITS'(int'($urandom_range(0, 1 << 18)) - (1 << 17)));
      else if (pick < 88) begin
        logic [2:0] s;
        s = 3'($urandom_range(0, 4));
        send_coef($urandom_range(0, 9), s, mild_coef(s));
      end else if (pick < 93)
        send_item(2'($urandom), 1'($urandom), SBITS'($urandom), 4'($urandom), 3'($urandom), $urandom);
      else if (pick < 97)
        send_item(CMD_CLEAR, 1'($urandom), SBITS'($urandom), 4'($urandom), 3'($urandom), $urandom);
      else
        send_item(CMD_UNUSED, 1'($urandom), SBITS'($urandom), 4'($urandom), 3'($urandom), $urandom);
    end
  endtask

  task automatic test_bypass_phases();
    write_bypass(1'b1);
    test_random(150);
    write_bypass(1'b0);
  endtask

  // result checker
  always @(posedge clk) begin
    eq_result_t w;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_samples.size() == 0) begin
        report("unexpected result", $sformatf("%0d", res_ch.out_sample), "none");
      end else begin
        w = pending_samples.pop_front();
        if (res_ch.out_sample !== w.smp)
          report("out_sample", $sformatf("%0d", res_ch.out_sample), $sformatf("%0d", w.smp));
        if (res_ch.out_channel !== w.ch)
          report("out_channel", $sformatf("%0d", res_ch.out_channel), $sformatf("%0d", w.ch));
      end
    end
  end

  // result back-pressure
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    item_ch.valid = 1'b0; item_ch.cmd = CMD_FILTER; item_ch.channel = 1'b0;
    item_ch.in_sample = '0; item_ch.band_index = '0; item_ch.coef_select = '0;
    item_ch.coef_value = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = 1'b0;
    for (int b = 0; b < BANDS; b++)
      for (int s = 0; s < NUM_SLOTS; s++) coef_tbl[b][s] = (s == 0) ? (32'sd1 <<< FRAC) : '0;
    clear_hist();
    bypass_on = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(800);
    wait_drained();
    test_bypass_phases();
    test_random(700);
    idle_enable = 1'b0;
    test_random(250);
    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[files.f]
src/geq_pkg.sv
src/geq_ifs.sv
src/geq_ram.sv
src/geq_front.sv
src/geq_back.sv
src/graphic_eq_biquad_cascade_core.sv
verif/graphic_eq_biquad_cascade_core_tb.sv
